@@ src/twst_pkg.sv @@
// Shared types and constants for the time window sum tracker.
package twst_pkg;

    // Time units per second; the age limit resets to one second.
    localparam logic [47:0] TIME_UNITS_PER_SECOND = 48'd1000000000;
    localparam logic [47:0] AGE_LIMIT_RESET       = TIME_UNITS_PER_SECOND;
    localparam int          DEPTH_DEFAULT         = 256;

    // Command codes.
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_EXPIRE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] value;
        logic [47:0] now;
    } t_in_word;

    typedef struct packed {
        logic [39:0] window_sum;
        logic [8:0]  entry_count;
        logic [31:0] newest_value;
    } t_out_word;

    // One ring entry: time stamp and value.
    typedef struct packed {
        logic [47:0] stamp;
        logic [31:0] value;
    } t_entry;

endpackage

@@ src/twst_ring_mem.sv @@
// Ring entry storage: one write port, one read port, registered read data.
module twst_ring_mem #(
    parameter int DEPTH = twst_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  twst_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output twst_pkg::t_entry o_rdata
);

    twst_pkg::t_entry r_mem [DEPTH];
    twst_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/time_window_sum_tracker_core.sv @@
// Top level of the time window sum tracker: sequencer, ring pointers and running sum.
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one word per item: a
//   command (add, expire, clear), a value and the current time stamp. Output channel
//   (o_out_valid / i_out_ready / o_out_word) returns one word per item: window sum,
//   entry count and newest held value (zero when empty).
//   i_cfg_we / i_cfg_wdata write the age limit; write it only while the block is idle.
// Sequence of states
//   Entries live in one synchronous ring memory with registered read data. Each eviction
//   check is a read followed by a compare (S_EV_RD, then S_EV_CHK) per examined entry.
//   Add: when the ring is full the oldest entry is first read and dropped; then the
//   new entry is written and the eviction checks run from the oldest entry.
//   Expire: the eviction checks run directly; an empty ring goes straight to done.
//   Clear and the unused code go straight to done. One item is worked at a time; the next
//   word is taken in the idle state, after the done state has loaded the result.
// Reset and stalls
//   Synchronous active-low reset empties the ring, zeroes the sum and loads the age
//   limit with one second; memory contents are not cleared. A result waits in the
//   output register while the receiver stalls; the next word is still accepted and
//   worked, and its result waits in the done state until the register frees.
module time_window_sum_tracker_core #(
    parameter int DEPTH = twst_pkg::DEPTH_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  twst_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output twst_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [47:0]         i_cfg_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DROP_RD,
        S_DROP,
        S_WRITE,
        S_EV_RD,
        S_EV_CHK,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_oldest_ptr;
    logic [AW-1:0]       r_next_ptr;
    logic [CW-1:0]       r_count;
    logic [39:0]         r_sum;
    logic [47:0]         r_age_limit;
    logic [31:0]         r_newest;
    logic [31:0]         r_value;
    logic [47:0]         r_now;
    logic [47:0]         r_cutoff;
    logic                r_out_valid;
    twst_pkg::t_out_word r_out_word;

    logic [47:0]         n_cutoff;
    twst_pkg::t_entry    mem_wdata;
    twst_pkg::t_entry    mem_rdata;
    logic                ring_full;
    logic                ring_empty;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // Cutoff saturates at zero when the age limit exceeds the time stamp.
    assign n_cutoff = (i_in_word.now >= r_age_limit) ? (i_in_word.now - r_age_limit) : '0;

    assign ring_full  = (r_count == CW'(DEPTH));
    assign ring_empty = (r_count == '0);

    assign mem_wdata.stamp = r_now;
    assign mem_wdata.value = r_value;

    // Read port always points at the oldest entry; data shows in the next cycle.
    twst_ring_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE),
        .i_waddr (r_next_ptr),
        .i_wdata (mem_wdata),
        .i_raddr (r_oldest_ptr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_oldest_ptr <= '0;
            r_next_ptr   <= '0;
            r_count      <= '0;
            r_sum        <= '0;
            r_age_limit  <= twst_pkg::AGE_LIMIT_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_age_limit <= i_cfg_wdata;
            end
            // Free the output register once its word is taken; the done state reloads it.
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_value  <= i_in_word.value;
                        r_now    <= i_in_word.now;
                        r_cutoff <= n_cutoff;
                        unique case (i_in_word.command)
                            twst_pkg::CMD_ADD: begin
                                r_state <= ring_full ? S_DROP_RD : S_WRITE;
                            end
                            twst_pkg::CMD_EXPIRE: begin
                                r_state <= S_EV_RD;
                            end
                            twst_pkg::CMD_CLEAR: begin
                                r_oldest_ptr <= '0;
                                r_next_ptr   <= '0;
                                r_count      <= '0;
                                r_sum        <= '0;
                                r_state      <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                // Full ring: wait for the oldest entry's value.
                S_DROP_RD: begin
                    r_state <= S_DROP;
                end
                S_DROP: begin
                    r_sum        <= r_sum - 40'(mem_rdata.value);
                    r_oldest_ptr <= ring_next(r_oldest_ptr);
                    r_count      <= r_count - CW'(1);
                    r_state      <= S_WRITE;
                end
                S_WRITE: begin
                    r_next_ptr <= ring_next(r_next_ptr);
                    r_count    <= r_count + CW'(1);
                    r_sum      <= r_sum + 40'(r_value);
                    r_newest   <= r_value;
                    r_state    <= S_EV_RD;
                end
                // Oldest pointer is settled; the read lands next cycle.
                S_EV_RD: begin
                    r_state <= ring_empty ? S_DONE : S_EV_CHK;
                end
                S_EV_CHK: begin
                    if (mem_rdata.stamp < r_cutoff) begin
                        r_sum        <= r_sum - 40'(mem_rdata.value);
                        r_oldest_ptr <= ring_next(r_oldest_ptr);
                        r_count      <= r_count - CW'(1);
                        r_state      <= S_EV_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                // Hold the result until the output register frees.
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid             <= 1'b1;
                        r_out_word.window_sum   <= r_sum;
                        r_out_word.entry_count  <= 9'(r_count);
                        r_out_word.newest_value <= ring_empty ? '0 : r_newest;
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ src/twst_checker.sv @@
// Port-level checker for the time window sum tracker, bound to the top level.
module twst_checker #(
    parameter int DEPTH = twst_pkg::DEPTH_DEFAULT
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input twst_pkg::t_out_word o_out_word
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed under stall");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid after reset");

    // One word at a time: an accept closes the input for the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word accepted while one is in work");

    // An empty ring reports zero sum and zero newest value (checked for depths below 512).
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.entry_count == 9'd0 && DEPTH < 512
        |-> o_out_word.window_sum == 40'd0 && o_out_word.newest_value == 32'd0)
        else $error("empty ring reports nonzero sum or value");

endmodule

bind time_window_sum_tracker_core twst_checker #(
    .DEPTH (DEPTH)
) u_twst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
